@@ rtl/dtcg_pkg.sv @@
// Shared types, constants and the quarter-wave sine table of the dual-tone cadence generator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package dtcg_pkg;

    localparam int SAMPLE_RATE  = 8000;
    localparam int MAX_SECTIONS = 4;
    localparam int TABLE_BITS   = 10;
    localparam int MS_PER_S     = 1000;

    localparam int NUM_SECTIONS = 4;
    localparam int SIDX_W       = 2;
    localparam int AMP_W        = 15;
    localparam int CNT_W        = 3;
    localparam int SEC_W        = 37;
    localparam int FREQ_W       = 12;
    localparam int DUR_W        = 13;
    localparam int LOAD_W       = 17;
    localparam int PHASE_W      = 32;
    localparam int SAMPLE_W     = 15;
    localparam int ENTRY_W      = 15;
    localparam int SINE_W       = 16;
    localparam int SCALE_W      = AMP_W - 2;
    localparam int PROD_W       = SCALE_W + 1 + SINE_W;
    localparam int CFG_IDX_W    = 3;

    // Division by the constant rates uses reciprocal multiplication, which is exact
    // for every numerator below 2^NUM_W.
    localparam int RATE_W       = $clog2(SAMPLE_RATE) + 1;
    localparam int NUM_W        = DUR_W + RATE_W;
    localparam int RCP_W        = 32;
    localparam int RPROD_W      = NUM_W + RCP_W;
    localparam int SHIFT_RATE   = NUM_W + $clog2(SAMPLE_RATE);
    localparam int SHIFT_MS     = NUM_W + $clog2(MS_PER_S);

    localparam logic [63:0] PHASE_ONE = 64'h1_0000_0000;
    localparam logic [63:0] PHASE_Q   = PHASE_ONE / 64'(SAMPLE_RATE);
    localparam logic [63:0] PHASE_R   = PHASE_ONE % 64'(SAMPLE_RATE);
    localparam logic [RCP_W-1:0] RCP_RATE =
        RCP_W'(((64'd1 << SHIFT_RATE) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE));
    localparam logic [RCP_W-1:0] RCP_MS =
        RCP_W'(((64'd1 << SHIFT_MS) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam int QUARTER      = 1 << (TABLE_BITS - 2);
    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
    localparam logic [AMP_W-1:0]  AMP_RESET = AMP_W'(16383);

    localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611B;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMPLITUDE     = 3'd0,
        REG_SECTION_COUNT = 3'd1,
        REG_SECTION_0     = 3'd2,
        REG_SECTION_1     = 3'd3,
        REG_SECTION_2     = 3'd4,
        REG_SECTION_3     = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        JOB_F1,
        JOB_F2,
        JOB_DUR
    } t_div_job;

    // Settings that the synthesis datapath reads on every sample.
    typedef struct packed {
        logic [AMP_W-1:0]                         amplitude;
        logic [CNT_W-1:0]                         section_count;
        logic [NUM_SECTIONS-1:0][PHASE_W-1:0]     step_lo;
        logic [NUM_SECTIONS-1:0][PHASE_W-1:0]     step_hi;
        logic [NUM_SECTIONS-1:0][LOAD_W-1:0]      load;
    } t_synth_cfg;

    typedef logic [QUARTER-1:0][ENTRY_W-1:0] t_qtab;

    // Q62 fixed-point product, keeping bits 125:62.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    // One table entry: round(32767 * sin(pi/2 * k / QUARTER)) from a Taylor series.
    function automatic logic [ENTRY_W-1:0] sine_entry(input int k);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] v;
        q  = HALF_PI_Q62 / QUARTER;
        r  = HALF_PI_Q62 % QUARTER;
        x  = q * 64'(k) + (r * 64'(k)) / QUARTER;
        x2 = mul_q62(x, x);
        s  = ONE_Q62;
        for (int n = 22; n >= 2; n -= 2) begin
            s = ONE_Q62 - mul_q62(x2, s) / 64'(n * (n + 1));
        end
        v = (mul_q62(mul_q62(x, s), 64'd65534) + 64'd1) >> 1;
        return v[ENTRY_W-1:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        for (int k = 0; k < QUARTER; k++) begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();
    localparam logic [ENTRY_W-1:0] QPEAK = sine_entry(QUARTER);

    // Full-wave sine from the top phase bits, using quarter-wave symmetry.
    function automatic logic signed [SINE_W-1:0] sine_at(input logic [PHASE_W-1:0] phase);
        logic [TABLE_BITS-1:0]   idx;
        logic [1:0]              quad;
        logic [TABLE_BITS-3:0]   k;
        logic [ENTRY_W-1:0]      e;
        logic signed [SINE_W-1:0] v;
        idx  = phase[PHASE_W-1 -: TABLE_BITS];
        quad = idx[TABLE_BITS-1 -: 2];
        k    = idx[TABLE_BITS-3:0];
        if (quad[0]) begin
            if (k == '0) begin
                e = QPEAK;
            end else begin
                e = QTAB[(TABLE_BITS-2)'(~k + 1'b1)];
            end
        end else begin
            e = QTAB[k];
        end
        v = $signed({1'b0, e});
        return quad[1] ? -v : v;
    endfunction

endpackage

@@ rtl/dtcg_if.sv @@
// Valid/ready channel interfaces of the dual-tone cadence generator: tick input,
// sample output and register writes. Depends on dtcg_pkg for field widths.
interface dtcg_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source(output valid, output restart, input ready);
    modport sink(input valid, input restart, output ready);
endinterface

interface dtcg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dtcg_pkg::SAMPLE_W-1:0] sample;
    logic [dtcg_pkg::SIDX_W-1:0]          section_index;
    logic                                 section_end;
    modport source(output valid, output sample, output section_index, output section_end,
                   input ready);
    modport sink(input valid, input sample, input section_index, input section_end,
                 output ready);
endinterface

interface dtcg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dtcg_pkg::CFG_IDX_W-1:0]     index;
    logic [dtcg_pkg::SEC_W-1:0]         data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/dtcg_cfg.sv @@
// Register file of the generator with a reciprocal-multiply unit that turns each section's
// frequencies and duration into phase steps and a sample count. Depends on dtcg_pkg, dtcg_if.
module dtcg_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dtcg_cfg_if.sink             i_cfg,
    output dtcg_pkg::t_synth_cfg o_cfg,
    output logic                 o_busy
);

    logic [dtcg_pkg::AMP_W-1:0]                              r_amp;
    logic [dtcg_pkg::CNT_W-1:0]                              r_count;
    logic [dtcg_pkg::NUM_SECTIONS-1:0][dtcg_pkg::PHASE_W-1:0] r_step_lo;
    logic [dtcg_pkg::NUM_SECTIONS-1:0][dtcg_pkg::PHASE_W-1:0] r_step_hi;
    logic [dtcg_pkg::NUM_SECTIONS-1:0][dtcg_pkg::LOAD_W-1:0]  r_load;

    logic                          r_busy;
    dtcg_pkg::t_div_job            r_job;
    logic                          r_stage;
    logic [dtcg_pkg::NUM_W-1:0]    r_num;
    logic [dtcg_pkg::PHASE_W-1:0]  r_base;
    logic [dtcg_pkg::SIDX_W-1:0]   r_sec;
    logic [dtcg_pkg::FREQ_W-1:0]   r_f1;
    logic [dtcg_pkg::FREQ_W-1:0]   r_f2;
    logic [dtcg_pkg::DUR_W-1:0]    r_dur;

    logic                          wr;
    logic                          sec_wr;
    logic [dtcg_pkg::FREQ_W-1:0]   freq;
    logic [dtcg_pkg::NUM_W-1:0]    num_freq;
    logic [dtcg_pkg::NUM_W-1:0]    num_dur;
    logic [dtcg_pkg::PHASE_W-1:0]  base;
    logic [dtcg_pkg::RCP_W-1:0]    rcp;
    logic [dtcg_pkg::RPROD_W-1:0]  prod;
    logic [dtcg_pkg::RPROD_W-1:0]  quo;
    logic [dtcg_pkg::PHASE_W-1:0]  step_val;
    logic [dtcg_pkg::LOAD_W-1:0]   load_val;

    assign i_cfg.ready = !r_busy;
    assign o_busy      = r_busy;
    assign wr          = i_cfg.valid && !r_busy;
    assign sec_wr      = wr && (i_cfg.index == dtcg_pkg::REG_SECTION_0 ||
                                i_cfg.index == dtcg_pkg::REG_SECTION_1 ||
                                i_cfg.index == dtcg_pkg::REG_SECTION_2 ||
                                i_cfg.index == dtcg_pkg::REG_SECTION_3);

    // A phase step is f*Q + floor(f*R / rate), where 2^32 = Q*rate + R. The first stage
    // forms the numerator, the second divides it by a reciprocal multiply.
    assign freq     = (r_job == dtcg_pkg::JOB_F1) ? r_f1 : r_f2;
    assign num_freq = dtcg_pkg::NUM_W'(freq) * dtcg_pkg::NUM_W'(dtcg_pkg::PHASE_R);
    assign num_dur  = dtcg_pkg::NUM_W'(r_dur) * dtcg_pkg::NUM_W'(dtcg_pkg::SAMPLE_RATE);
    assign base     = dtcg_pkg::PHASE_W'(freq) * dtcg_pkg::PHASE_W'(dtcg_pkg::PHASE_Q);
    assign rcp      = (r_job == dtcg_pkg::JOB_DUR) ? dtcg_pkg::RCP_MS : dtcg_pkg::RCP_RATE;
    assign prod     = dtcg_pkg::RPROD_W'(r_num) * dtcg_pkg::RPROD_W'(rcp);
    assign quo      = (r_job == dtcg_pkg::JOB_DUR) ? (prod >> dtcg_pkg::SHIFT_MS)
                                                   : (prod >> dtcg_pkg::SHIFT_RATE);
    assign step_val = r_base + dtcg_pkg::PHASE_W'(quo);

    always_comb begin
        if (quo > dtcg_pkg::RPROD_W'(dtcg_pkg::LOAD_MAX)) begin
            load_val = dtcg_pkg::LOAD_MAX;
        end else if (r_dur != '0 && quo == '0) begin
            load_val = dtcg_pkg::LOAD_W'(1);
        end else begin
            load_val = quo[dtcg_pkg::LOAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp     <= dtcg_pkg::AMP_RESET;
            r_count   <= dtcg_pkg::CNT_W'(1);
            r_step_lo <= '0;
            r_step_hi <= '0;
            r_load    <= '0;
            r_busy    <= 1'b0;
            r_job     <= dtcg_pkg::JOB_F1;
            r_stage   <= 1'b0;
        end else if (r_busy) begin
            r_stage <= !r_stage;
            if (r_stage) begin
                unique case (r_job)
                    dtcg_pkg::JOB_F1: begin
                        r_step_lo[r_sec] <= step_val;
                        r_job            <= dtcg_pkg::JOB_F2;
                    end
                    dtcg_pkg::JOB_F2: begin
                        r_step_hi[r_sec] <= step_val;
                        r_job            <= dtcg_pkg::JOB_DUR;
                    end
                    dtcg_pkg::JOB_DUR: begin
                        r_load[r_sec] <= load_val;
                        r_busy        <= 1'b0;
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end else if (wr) begin
            unique case (i_cfg.index)
                dtcg_pkg::REG_AMPLITUDE: begin
                    r_amp <= i_cfg.data[dtcg_pkg::AMP_W-1:0];
                end
                dtcg_pkg::REG_SECTION_COUNT: begin
                    r_count <= i_cfg.data[dtcg_pkg::CNT_W-1:0];
                end
                dtcg_pkg::REG_SECTION_0, dtcg_pkg::REG_SECTION_1,
                dtcg_pkg::REG_SECTION_2, dtcg_pkg::REG_SECTION_3: begin
                    r_busy  <= 1'b1;
                    r_job   <= dtcg_pkg::JOB_F1;
                    r_stage <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Numerator stage and the latched fields of the section being written.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (!r_stage) begin
                r_num  <= (r_job == dtcg_pkg::JOB_DUR) ? num_dur : num_freq;
                r_base <= base;
            end
        end else if (sec_wr) begin
            r_f1  <= i_cfg.data[dtcg_pkg::FREQ_W-1:0];
            r_f2  <= i_cfg.data[2*dtcg_pkg::FREQ_W-1 -: dtcg_pkg::FREQ_W];
            r_dur <= i_cfg.data[dtcg_pkg::SEC_W-1 -: dtcg_pkg::DUR_W];
            r_sec <= dtcg_pkg::SIDX_W'(i_cfg.index - dtcg_pkg::CFG_IDX_W'(dtcg_pkg::REG_SECTION_0));
        end
    end

    assign o_cfg.amplitude     = r_amp;
    assign o_cfg.section_count = r_count;
    assign o_cfg.step_lo       = r_step_lo;
    assign o_cfg.step_hi       = r_step_hi;
    assign o_cfg.load          = r_load;

endmodule

@@ rtl/dtcg_front.sv @@
// Front end: takes tick transactions, tags restarts and holds them in a short queue
// so the synthesis pipeline can stall on its own. Depends on dtcg_pkg, dtcg_if.
module dtcg_front (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dtcg_in_if.sink  i_in,
    input  logic     i_busy,
    output logic     o_q_valid,
    output logic     o_q_restart,
    input  logic     i_q_ready
);

    logic [dtcg_pkg::QUEUE_DEPTH-1:0] r_mem;
    logic [dtcg_pkg::QPTR_W-1:0] r_wr;
    logic [dtcg_pkg::QPTR_W-1:0] r_rd;
    logic [dtcg_pkg::QPTR_W:0]   r_cnt;
    logic                        push;
    logic                        pop;

    // Ticks are held off while a section's settings are being recomputed.
    assign i_in.ready  = (r_cnt != (dtcg_pkg::QPTR_W + 1)'(dtcg_pkg::QUEUE_DEPTH)) && !i_busy;
    assign push        = i_in.valid && i_in.ready;
    assign o_q_valid   = r_cnt != '0;
    assign o_q_restart = r_mem[r_rd];
    assign pop         = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (dtcg_pkg::QPTR_W + 1)'(push) - (dtcg_pkg::QPTR_W + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_in.restart;
        end
    end

endmodule

@@ rtl/dtcg_back.sv @@
// Back end: cadence and phase state update, sine lookup, amplitude scaling and the output
// register, one sample per cycle unless the output stalls. Depends on dtcg_pkg, dtcg_if.
module dtcg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dtcg_pkg::t_synth_cfg i_cfg,
    input  logic                 i_q_valid,
    input  logic                 i_q_restart,
    output logic                 o_q_ready,
    dtcg_out_if.source           o_out
);

    // Cadence state.
    logic [dtcg_pkg::PHASE_W-1:0] r_ph_lo;
    logic [dtcg_pkg::PHASE_W-1:0] r_ph_hi;
    logic [dtcg_pkg::SIDX_W-1:0]  r_cur;
    logic [dtcg_pkg::LOAD_W-1:0]  r_left;
    logic                         r_pend;

    logic [dtcg_pkg::PHASE_W-1:0] n_ph_lo;
    logic [dtcg_pkg::PHASE_W-1:0] n_ph_hi;
    logic [dtcg_pkg::SIDX_W-1:0]  n_cur;
    logic [dtcg_pkg::LOAD_W-1:0]  n_left;
    logic                         n_pend;

    logic [dtcg_pkg::PHASE_W-1:0] a_ph_lo;
    logic [dtcg_pkg::PHASE_W-1:0] a_ph_hi;
    logic [dtcg_pkg::SIDX_W-1:0]  a_cur;
    logic [dtcg_pkg::LOAD_W-1:0]  a_left;
    logic                         a_end;
    logic [dtcg_pkg::CNT_W-1:0]   a_count;
    logic [dtcg_pkg::SIDX_W-1:0]  a_wrap;

    // Pipeline stages.
    logic                                r1_valid;
    logic [dtcg_pkg::PHASE_W-1:0]        r1_ph_lo;
    logic [dtcg_pkg::PHASE_W-1:0]        r1_ph_hi;
    logic [dtcg_pkg::SIDX_W-1:0]         r1_idx;
    logic                                r1_end;
    logic                                r2_valid;
    logic signed [dtcg_pkg::SINE_W-1:0]  r2_sin_lo;
    logic signed [dtcg_pkg::SINE_W-1:0]  r2_sin_hi;
    logic [dtcg_pkg::SIDX_W-1:0]         r2_idx;
    logic                                r2_end;
    logic                                r3_valid;
    logic signed [dtcg_pkg::PROD_W-1:0]  r3_p_lo;
    logic signed [dtcg_pkg::PROD_W-1:0]  r3_p_hi;
    logic [dtcg_pkg::SIDX_W-1:0]         r3_idx;
    logic                                r3_end;
    logic                                r_out_valid;
    logic signed [dtcg_pkg::SAMPLE_W-1:0] r_sample;
    logic [dtcg_pkg::SIDX_W-1:0]         r_out_idx;
    logic                                r_out_end;

    logic                                 adv;
    logic                                 take;
    logic signed [dtcg_pkg::SCALE_W:0]    amp_q;
    logic signed [dtcg_pkg::PROD_W-1:0]   sum;

    // The whole pipeline moves together unless an output result waits on a receiver that is not ready.
    assign adv       = !r_out_valid || o_out.ready;
    assign o_q_ready = adv;
    assign take      = i_q_valid && adv;

    always_comb begin
        if (i_cfg.section_count == '0) begin
            a_count = dtcg_pkg::CNT_W'(1);
        end else if (i_cfg.section_count > dtcg_pkg::CNT_W'(dtcg_pkg::MAX_SECTIONS)) begin
            a_count = dtcg_pkg::CNT_W'(dtcg_pkg::MAX_SECTIONS);
        end else begin
            a_count = i_cfg.section_count;
        end
    end

    // A restart acts before the sample: section zero, zero phase, fresh duration.
    always_comb begin
        a_cur   = i_q_restart ? '0 : r_cur;
        a_ph_lo = i_q_restart ? '0 : r_ph_lo;
        a_ph_hi = i_q_restart ? '0 : r_ph_hi;
        a_left  = (i_q_restart || r_pend) ? i_cfg.load[a_cur] : r_left;
        a_end   = a_left == dtcg_pkg::LOAD_W'(1);
        a_wrap  = ((dtcg_pkg::CNT_W'(a_cur) + 1'b1) >= a_count) ? '0 : a_cur + 1'b1;

        n_left  = (a_left != '0) ? a_left - 1'b1 : '0;
        n_pend  = a_end;
        n_cur   = a_end ? a_wrap : a_cur;
        n_ph_lo = a_end ? '0 : a_ph_lo + i_cfg.step_lo[a_cur];
        n_ph_hi = a_end ? '0 : a_ph_hi + i_cfg.step_hi[a_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_lo     <= '0;
            r_ph_hi     <= '0;
            r_cur       <= '0;
            r_left      <= '0;
            r_pend      <= 1'b1;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            if (take) begin
                r_ph_lo <= n_ph_lo;
                r_ph_hi <= n_ph_hi;
                r_cur   <= n_cur;
                r_left  <= n_left;
                r_pend  <= n_pend;
            end
            r1_valid    <= take;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    assign amp_q = $signed({1'b0, i_cfg.amplitude[dtcg_pkg::AMP_W-1:2]});
    assign sum   = (r3_p_lo >>> 15) + (r3_p_hi >>> 15);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ph_lo  <= a_ph_lo;
            r1_ph_hi  <= a_ph_hi;
            r1_idx    <= a_cur;
            r1_end    <= a_end;

            r2_sin_lo <= dtcg_pkg::sine_at(r1_ph_lo);
            r2_sin_hi <= dtcg_pkg::sine_at(r1_ph_hi);
            r2_idx    <= r1_idx;
            r2_end    <= r1_end;

            r3_p_lo   <= amp_q * r2_sin_lo;
            r3_p_hi   <= amp_q * r2_sin_hi;
            r3_idx    <= r2_idx;
            r3_end    <= r2_end;

            r_sample  <= sum[dtcg_pkg::SAMPLE_W-1:0];
            r_out_idx <= r3_idx;
            r_out_end <= r3_end;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sample        = r_sample;
    assign o_out.section_index = r_out_idx;
    assign o_out.section_end   = r_out_end;

endmodule

@@ rtl/dual_tone_cadence_generator_unit.sv @@
// Dual-tone call-progress cadence generator: one 15-bit audio sample per tick transaction.
// A result passes through the tick queue, the r1, r2 and r3 stages and the output register.
// Throughput: one tick per cycle, set by the phase and cadence state update, unless the output
// stalls. A section register write keeps the settings unit busy for a numerator and a reciprocal
// multiply per phase step and per sample count; ticks and further writes are held off meanwhile.
// Reset is synchronous and active low; it restores the register defaults and clears the queue,
// pipeline and cadence state.
module dual_tone_cadence_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtcg_in_if.sink     i_in,
    dtcg_cfg_if.sink    i_cfg,
    dtcg_out_if.source  o_out
);

    dtcg_pkg::t_synth_cfg synth_cfg;
    logic                 busy;
    logic                 q_valid;
    logic                 q_restart;
    logic                 q_ready;

    dtcg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (synth_cfg),
        .o_busy  (busy)
    );

    dtcg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_busy      (busy),
        .o_q_valid   (q_valid),
        .o_q_restart (q_restart),
        .i_q_ready   (q_ready)
    );

    dtcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (synth_cfg),
        .i_q_valid   (q_valid),
        .i_q_restart (q_restart),
        .o_q_ready   (q_ready),
        .o_out       (o_out)
    );

endmodule

@@ tb/dual_tone_cadence_generator_unit_tb.sv @@
// Self-checking testbench for the dual-tone cadence generator: directed and random tick traffic,
// register rewrites between phases and random stalls on both channels, checked against a model.
// Depends on dtcg_pkg, the dtcg channel interfaces and dual_tone_cadence_generator_unit.
`timescale 1ns / 100ps

module dual_tone_cadence_generator_unit_tb;

    localparam int WAVE_QUARTER   = 1 << (dtcg_pkg::TABLE_BITS - 2);
    localparam int MS_PER_SECOND  = 1000;
    localparam int SAMPLES_CAP    = 131071;
    localparam int AMP_MAX        = 32767;
    localparam int COUNT_FIELD_MAX = 7;
    localparam int FREQ_MAX       = (1 << dtcg_pkg::FREQ_W) - 1;
    localparam int DUR_MAX        = (1 << dtcg_pkg::DUR_W) - 1;
    localparam int TICK_TARGET    = 1450;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q62_HALF_PI = 64'h6487_ED51_10B4_611B;

    // Register indexes past the end of the map; writes to them must be ignored.
    localparam logic [dtcg_pkg::CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [dtcg_pkg::CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

    typedef struct packed {
        logic signed [dtcg_pkg::SAMPLE_W-1:0] sample;
        logic [dtcg_pkg::SIDX_W-1:0]          section_index;
        logic                                 section_end;
    } t_tone_result;

    logic i_clk;
    logic i_rst_n;

    dtcg_in_if  tick_if();
    dtcg_cfg_if cfg_if();
    dtcg_out_if tone_if();

    dual_tone_cadence_generator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .i_cfg   (cfg_if),
        .o_out   (tone_if)
    );

    // Register copies and cadence state of the expected-sample calculation.
    logic [dtcg_pkg::AMP_W-1:0]   amp_setting;
    logic [dtcg_pkg::CNT_W-1:0]   count_setting;
    logic [dtcg_pkg::SEC_W-1:0]   section_setting [dtcg_pkg::NUM_SECTIONS];
    logic [dtcg_pkg::PHASE_W-1:0] phase_a;
    logic [dtcg_pkg::PHASE_W-1:0] phase_b;
    logic [dtcg_pkg::SIDX_W-1:0]  cadence_section;
    logic [dtcg_pkg::LOAD_W-1:0]  samples_to_go;
    logic                         reload_due;
    int                           quarter_wave [0:WAVE_QUARTER];

    t_tone_result expected_samples [$];
    int           mismatches;
    int           ticks_sent;
    bit           steady_flow;
    int           hold_request;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Quarter-wave table of round(32767*sin) from a fixed-point Taylor series.
    function automatic void build_sine_table();
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        q = Q62_HALF_PI / WAVE_QUARTER;
        r = Q62_HALF_PI % WAVE_QUARTER;
        for (int k = 0; k <= WAVE_QUARTER; k++) begin
            x  = q * 64'(k) + (r * 64'(k)) / WAVE_QUARTER;
            x2 = q62_mul(x, x);
            s  = Q62_ONE;
            for (int n = 22; n >= 2; n -= 2) begin
                s = Q62_ONE - q62_mul(x2, s) / 64'(n * (n + 1));
            end
            quarter_wave[k] = int'((q62_mul(q62_mul(x, s), 64'd65534) + 64'd1) >> 1);
        end
    endfunction

    function automatic int sine_of(input logic [dtcg_pkg::PHASE_W-1:0] ph);
        logic [dtcg_pkg::TABLE_BITS-1:0] idx;
        int k;
        int v;
        idx = ph[dtcg_pkg::PHASE_W-1 -: dtcg_pkg::TABLE_BITS];
        k   = int'(idx[dtcg_pkg::TABLE_BITS-3:0]);
        v   = idx[dtcg_pkg::TABLE_BITS-2] ? quarter_wave[WAVE_QUARTER - k] : quarter_wave[k];
        return idx[dtcg_pkg::TABLE_BITS-1] ? -v : v;
    endfunction

    // Arithmetic shift gives the floor of the scaled product.
    function automatic int scaled(input int amp, input int sine);
        return (amp * sine) >>> 15;
    endfunction

    function automatic logic [dtcg_pkg::PHASE_W-1:0] phase_increment(
            input logic [dtcg_pkg::FREQ_W-1:0] hz);
        logic [63:0] num;
        num = {20'd0, hz, 32'd0} / 64'(dtcg_pkg::SAMPLE_RATE);
        return num[dtcg_pkg::PHASE_W-1:0];
    endfunction

    function automatic void reset_model();
        amp_setting     = dtcg_pkg::AMP_W'(16383);
        count_setting   = dtcg_pkg::CNT_W'(1);
        for (int s = 0; s < dtcg_pkg::NUM_SECTIONS; s++) section_setting[s] = '0;
        phase_a         = '0;
        phase_b         = '0;
        cadence_section = '0;
        samples_to_go   = '0;
        reload_due      = 1'b1;
    endfunction

    function automatic void apply_reg(input logic [dtcg_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [dtcg_pkg::SEC_W-1:0] value);
        case (idx)
            dtcg_pkg::REG_AMPLITUDE:     amp_setting = value[dtcg_pkg::AMP_W-1:0];
            dtcg_pkg::REG_SECTION_COUNT: count_setting = value[dtcg_pkg::CNT_W-1:0];
            dtcg_pkg::REG_SECTION_0:     section_setting[0] = value;
            dtcg_pkg::REG_SECTION_1:     section_setting[1] = value;
            dtcg_pkg::REG_SECTION_2:     section_setting[2] = value;
            dtcg_pkg::REG_SECTION_3:     section_setting[3] = value;
            default: ;
        endcase
    endfunction

    function automatic t_tone_result synth_tick(input logic restart);
        t_tone_result                res;
        logic [dtcg_pkg::SIDX_W-1:0] sec;
        logic [dtcg_pkg::SEC_W-1:0]  setting;
        logic [dtcg_pkg::DUR_W-1:0]  ms;
        logic [63:0]                 load;
        int                          span;
        int                          amp;
        int                          mix;
        if (restart) begin
            cadence_section = '0;
            phase_a         = '0;
            phase_b         = '0;
            reload_due      = 1'b1;
        end
        sec     = cadence_section;
        setting = section_setting[sec];
        if (reload_due) begin
            ms   = setting[dtcg_pkg::SEC_W-1 -: dtcg_pkg::DUR_W];
            load = 64'(ms) * dtcg_pkg::SAMPLE_RATE / MS_PER_SECOND;
            if (load > SAMPLES_CAP) load = 64'(SAMPLES_CAP);
            if (ms != 0 && load == 0) load = 64'd1;
            samples_to_go = load[dtcg_pkg::LOAD_W-1:0];
            reload_due    = 1'b0;
        end
        amp = int'(amp_setting >> 2);
        mix = scaled(amp, sine_of(phase_a)) + scaled(amp, sine_of(phase_b));
        phase_a += phase_increment(setting[dtcg_pkg::FREQ_W-1:0]);
        phase_b += phase_increment(setting[2*dtcg_pkg::FREQ_W-1:dtcg_pkg::FREQ_W]);
        res.section_end = 1'b0;
        if (samples_to_go != 0) begin
            samples_to_go--;
            if (samples_to_go == 0) begin
                // Out-of-range counts clamp; a section past the count wraps to zero.
                span = int'(count_setting);
                if (span == 0) span = 1;
                if (span > dtcg_pkg::MAX_SECTIONS) span = dtcg_pkg::MAX_SECTIONS;
                cadence_section = (int'(sec) + 1 >= span) ? '0 : sec + 1'b1;
                phase_a         = '0;
                phase_b         = '0;
                reload_due      = 1'b1;
                res.section_end = 1'b1;
            end
        end
        res.sample        = dtcg_pkg::SAMPLE_W'(mix);
        res.section_index = sec;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [dtcg_pkg::SEC_W-1:0] pack_section(input int f_one, input int f_two,
                                                                input int ms);
        return {dtcg_pkg::DUR_W'(ms), dtcg_pkg::FREQ_W'(f_two), dtcg_pkg::FREQ_W'(f_one)};
    endfunction

    // Mostly short timed sections so that the cadence steps often.
    function automatic logic [dtcg_pkg::SEC_W-1:0] random_section();
        int ms;
        case ($urandom_range(0, 9))
            0:       ms = 0;
            1:       ms = $urandom_range(0, DUR_MAX);
            default: ms = $urandom_range(1, 6);
        endcase
        return pack_section($urandom_range(0, FREQ_MAX), $urandom_range(0, FREQ_MAX), ms);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic wait_idle();
        tick_if.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dtcg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dtcg_pkg::SEC_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_reg(idx, value);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_tick(input logic restart);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_if.valid   <= 1'b1;
        tick_if.restart <= restart;
        do @(posedge i_clk); while (!tick_if.ready);
        expected_samples.push_back(synth_tick(restart));
        ticks_sent++;
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_field_extremes();
        write_reg(dtcg_pkg::REG_AMPLITUDE, dtcg_pkg::SEC_W'(AMP_MAX));
        write_reg(dtcg_pkg::REG_SECTION_COUNT, dtcg_pkg::SEC_W'(COUNT_FIELD_MAX));
        write_reg(dtcg_pkg::REG_SECTION_0, '1);
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        write_reg(dtcg_pkg::REG_AMPLITUDE, '0);
        send_tick(1'b0);
    endtask

    // A count of zero acts as one, so a 1 ms section ends and wraps onto itself.
    task automatic test_single_section_wrap();
        write_reg(dtcg_pkg::REG_AMPLITUDE, dtcg_pkg::SEC_W'(20000));
        write_reg(dtcg_pkg::REG_SECTION_COUNT, '0);
        write_reg(dtcg_pkg::REG_SECTION_0, pack_section(350, 440, 1));
        send_tick(1'b1);
        repeat (8) send_tick(1'b0);
    endtask

    // New frequencies apply at once; the new duration waits for the next section start.
    task automatic test_live_rewrite();
        write_reg(dtcg_pkg::REG_SECTION_0, pack_section(480, 620, 1));
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        write_reg(dtcg_pkg::REG_SECTION_0, pack_section(1000, 0, 5));
        repeat (3) send_tick(1'b0);
    endtask

    task automatic test_ignored_index();
        write_reg(REG_SPARE_LOW, '1);
        write_reg(REG_SPARE_HIGH, '1);
        send_tick(1'b0);
    endtask

    // The receiver holds off while ticks keep coming, so the block must stall its input.
    task automatic test_output_backpressure();
        write_reg(dtcg_pkg::REG_SECTION_COUNT, dtcg_pkg::SEC_W'(dtcg_pkg::MAX_SECTIONS));
        write_reg(dtcg_pkg::REG_SECTION_0, pack_section(425, 425, 2));
        write_reg(dtcg_pkg::REG_SECTION_1, random_section());
        steady_flow  = 1'b1;
        hold_request = HOLD_CYCLES;
        send_tick(1'b1);
        repeat (39) send_tick(1'b0);
        steady_flow = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_cadences();
        logic [dtcg_pkg::SEC_W-1:0] value;
        int                         phase_len;
        while (ticks_sent < TICK_TARGET) begin
            steady_flow = 1'b0;
            if ($urandom_range(0, 1) == 0) begin
                value = dtcg_pkg::SEC_W'({$urandom, $urandom});
                case ($urandom_range(0, 4))
                    0:       value[dtcg_pkg::AMP_W-1:0] = '0;
                    1:       value[dtcg_pkg::AMP_W-1:0] = dtcg_pkg::AMP_W'(AMP_MAX);
                    default: value[dtcg_pkg::AMP_W-1:0] =
                                 dtcg_pkg::AMP_W'($urandom_range(0, AMP_MAX));
                endcase
                write_reg(dtcg_pkg::REG_AMPLITUDE, value);
            end
            if ($urandom_range(0, 1) == 0) begin
                value = dtcg_pkg::SEC_W'({$urandom, $urandom});
                value[dtcg_pkg::CNT_W-1:0] = ($urandom_range(0, 4) == 0) ?
                    dtcg_pkg::CNT_W'($urandom_range(0, COUNT_FIELD_MAX)) :
                    dtcg_pkg::CNT_W'($urandom_range(1, dtcg_pkg::MAX_SECTIONS));
                write_reg(dtcg_pkg::REG_SECTION_COUNT, value);
            end
            for (int s = 0; s < dtcg_pkg::NUM_SECTIONS; s++) begin
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(dtcg_pkg::CFG_IDX_W'(dtcg_pkg::REG_SECTION_0 + s),
                              random_section());
                end
            end
            steady_flow = ($urandom_range(0, 3) == 0);
            phase_len   = $urandom_range(8, 60);
            repeat (phase_len) send_tick($urandom_range(0, 15) == 0);
            wait_idle();
        end
        steady_flow = 1'b0;
    endtask

    initial begin : sample_receiver
        int stall_left;
        stall_left = 0;
        tone_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 2) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                tone_if.ready <= 1'b0;
                stall_left--;
            end else begin
                tone_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : sample_checker
        t_tone_result want;
        if (i_rst_n && tone_if.valid && tone_if.ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected sample", longint'(tone_if.sample), longint'(0));
            end else begin
                want = expected_samples.pop_front();
                if (tone_if.sample !== want.sample)
                    report_mismatch("sample", longint'(tone_if.sample), longint'(want.sample));
                if (tone_if.section_index !== want.section_index)
                    report_mismatch("section_index", longint'(tone_if.section_index),
                                    longint'(want.section_index));
                if (tone_if.section_end !== want.section_end)
                    report_mismatch("section_end", longint'(tone_if.section_end),
                                    longint'(want.section_end));
            end
        end
    end

    initial begin : stall_watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (tick_if.valid && tick_if.ready) ||
                (tone_if.valid && tone_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        mismatches   = 0;
        ticks_sent   = 0;
        steady_flow  = 1'b0;
        hold_request = 0;
        tick_if.valid   <= 1'b0;
        tick_if.restart <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= dtcg_pkg::REG_AMPLITUDE;
        cfg_if.data     <= '0;
        i_rst_n         <= 1'b0;
        reset_model();
        build_sine_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_single_section_wrap();
        test_live_rewrite();
        test_ignored_index();
        test_output_backpressure();
        test_random_cadences();

        wait_idle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dtcg_pkg.sv
rtl/dtcg_if.sv
rtl/dtcg_cfg.sv
rtl/dtcg_front.sv
rtl/dtcg_back.sv
rtl/dual_tone_cadence_generator_unit.sv
tb/dual_tone_cadence_generator_unit_tb.sv
